@@ src/timeline_event_scheduler_assert.svh @@
// assertion macros for the timeline event scheduler checker
// depends on nothing; included by the checker file
`ifndef TIMELINE_EVENT_SCHEDULER_ASSERT_SVH
`define TIMELINE_EVENT_SCHEDULER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TES_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tes check failed");

// next-cycle implication, disabled in reset
`define TES_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tes check failed");

`endif

@@ src/tes_pkg.sv @@
// shared codes and helpers for the timeline event scheduler
// no dependencies
package tes_pkg;

   localparam logic [2:0] FUNC_TICK       = 3'd0;
   localparam logic [2:0] FUNC_ADD_PT_ABS = 3'd1;
   localparam logic [2:0] FUNC_ADD_PT_DLY = 3'd2;
   localparam logic [2:0] FUNC_ADD_RG_ABS = 3'd3;
   localparam logic [2:0] FUNC_ADD_RG_DLY = 3'd4;
   localparam logic [2:0] FUNC_STOP       = 3'd5;
   localparam logic [2:0] FUNC_REMOVE     = 3'd6;

   localparam logic [2:0] KIND_ASSIGNED = 3'd0;
   localparam logic [2:0] KIND_FULL     = 3'd1;
   localparam logic [2:0] KIND_FIRED    = 3'd2;
   localparam logic [2:0] KIND_STARTED  = 3'd3;
   localparam logic [2:0] KIND_PROGRESS = 3'd4;
   localparam logic [2:0] KIND_ENDED    = 3'd5;
   localparam logic [2:0] KIND_DONE     = 3'd6;

   localparam logic [16:0] FULL_PROGRESS = 17'h10000;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_PSCAN = 8'b0000_0010,
      ST_PFIRE = 8'b0000_0100,
      ST_RCHK  = 8'b0000_1000,
      ST_RPROG = 8'b0001_0000,
      ST_RDIV  = 8'b0010_0000,
      ST_REND  = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } seq_state_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quotient;
   } div_status_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat_add = s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

@@ src/tes_div.sv @@
// radix-2 restoring divider for range progress, one quotient bit per cycle
// depends on tes_pkg
module tes_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [31:0]             dividend_hi,
   input  logic [31:0]             divisor,
   output tes_pkg::div_status_type status
);
   import tes_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [15:0] q_ff, q_in;
   logic [32:0] shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      shifted = {rem_ff, 1'b0};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 4'd0;
         rem_in  = dividend_hi;
         den_in  = divisor;
         q_in    = 16'd0;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = 32'(shifted - {1'b0, den_ff});
            q_in   = {q_ff[14:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            q_in   = {q_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = q_ff;

endmodule

@@ src/timeline_event_scheduler.sv @@
// Timed event scheduler: a saturating Q16.16 clock, a table of one-shot point events
// and a table of range events with progress, driven by one command per transfer.
// Add, stop, remove and unused commands finish in the accept cycle; their single
// result appears in the next cycle and busy never rises. A tick holds busy high
// through point scanning and firing (one full pass over the point table through a
// single comparator per fired point, then a firing step for it), then through each
// range slot in turn (an idle slot is only checked; a live one may use the shared
// 16-step divider with its load and handoff), then through the closing done result.
// Each result is on the rsp_ ports for exactly one cycle with rsp_valid high; the
// receiver cannot stall it.
// depends on tes_pkg and tes_div
module timeline_event_scheduler #(
   parameter int POINT_SLOTS = 16,
   parameter int RANGE_SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [31:0] req_tick_delta,
   input  logic [31:0] req_start_time,
   input  logic [31:0] req_end_time,
   input  logic [31:0] req_delay_time,
   input  logic [7:0]  req_owner_tag,
   input  logic [15:0] req_target_id,
   output logic        rsp_valid,
   output logic [2:0]  rsp_kind,
   output logic [15:0] rsp_event_id,
   output logic [7:0]  rsp_event_owner,
   output logic [16:0] rsp_progress,
   output logic        rsp_last
);
   import tes_pkg::*;

   localparam int PW = (POINT_SLOTS > 1) ? $clog2(POINT_SLOTS) : 1;
   localparam int RW = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;
   localparam logic [PW-1:0] PLAST = PW'(POINT_SLOTS - 1);
   localparam logic [RW-1:0] RLAST = RW'(RANGE_SLOTS - 1);

   // sequencer and clock state
   seq_state_type state_ff, state_in;
   logic [31:0]   time_ff, time_in;
   logic [15:0]   next_id_ff, next_id_in;

   // point table: live bits in flops, payload written at one slot
   logic [POINT_SLOTS-1:0] pt_live_ff, pt_live_in;
   logic [31:0] pt_trig_ff  [POINT_SLOTS];
   logic [15:0] pt_ident_ff [POINT_SLOTS];
   logic [7:0]  pt_owner_ff [POINT_SLOTS];
   logic          pt_we;
   logic [PW-1:0] pt_wslot;
   logic [31:0]   pt_wtrig;

   // range table
   logic [RANGE_SLOTS-1:0] rg_live_ff, rg_live_in;
   logic [RANGE_SLOTS-1:0] rg_begun_ff, rg_begun_in;
   logic [31:0] rg_start_ff [RANGE_SLOTS];
   logic [31:0] rg_end_ff   [RANGE_SLOTS];
   logic [15:0] rg_ident_ff [RANGE_SLOTS];
   logic [7:0]  rg_owner_ff [RANGE_SLOTS];
   logic          rg_we;
   logic [RW-1:0] rg_wslot;
   logic [31:0]   rg_wstart, rg_wend;

   // scan registers for the earliest-due point search
   logic [PW-1:0] pidx_ff, pidx_in;
   logic          found_ff, found_in;
   logic [31:0]   btrig_ff, btrig_in;
   logic [15:0]   bid_ff, bid_in;
   logic [7:0]    bowner_ff, bowner_in;
   logic [PW-1:0] bslot_ff, bslot_in;
   logic [RW-1:0] ridx_ff, ridx_in;

   // result registers
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_kind_ff, rsp_kind_in;
   logic [15:0] rsp_id_ff, rsp_id_in;
   logic [7:0]  rsp_owner_ff, rsp_owner_in;
   logic [16:0] rsp_prog_ff, rsp_prog_in;
   logic        rsp_last_ff, rsp_last_in;

   // shared divider
   logic           div_start;
   div_status_type div_stat;

   // free slot and stop-match search over the live bits
   logic          pfree_found, rfree_found, pstop_found, rstop_found;
   logic [PW-1:0] pfree_slot, pstop_slot;
   logic [RW-1:0] rfree_slot, rstop_slot;
   logic          cand;
   logic [31:0]   cur_trig, cur_start, cur_end, add_trig, add_start, add_end;

   tes_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .dividend_hi (time_ff - cur_start),
      .divisor     (cur_end - cur_start),
      .status      (div_stat)
   );

   always_comb begin
      pfree_found = 1'b0;
      pfree_slot  = '0;
      pstop_found = 1'b0;
      pstop_slot  = '0;
      for (int i = POINT_SLOTS - 1; i >= 0; i--) begin
         if (!pt_live_ff[i]) begin
            pfree_found = 1'b1;
            pfree_slot  = PW'(i);
         end
         if (pt_live_ff[i] && pt_ident_ff[i] == req_target_id) begin
            pstop_found = 1'b1;
            pstop_slot  = PW'(i);
         end
      end
      rfree_found = 1'b0;
      rfree_slot  = '0;
      rstop_found = 1'b0;
      rstop_slot  = '0;
      for (int j = RANGE_SLOTS - 1; j >= 0; j--) begin
         if (!rg_live_ff[j]) begin
            rfree_found = 1'b1;
            rfree_slot  = RW'(j);
         end
         if (rg_live_ff[j] && rg_ident_ff[j] == req_target_id) begin
            rstop_found = 1'b1;
            rstop_slot  = RW'(j);
         end
      end
   end

   assign cur_trig  = pt_trig_ff[pidx_ff];
   assign cur_start = rg_start_ff[ridx_ff];
   assign cur_end   = rg_end_ff[ridx_ff];
   assign add_trig  = (req_func == FUNC_ADD_PT_ABS) ? req_start_time
                                                    : sat_add(time_ff, req_delay_time);
   assign add_start = (req_func == FUNC_ADD_RG_ABS) ? req_start_time
                                                    : sat_add(req_start_time, req_delay_time);
   assign add_end   = (req_func == FUNC_ADD_RG_ABS) ? req_end_time
                                                    : sat_add(req_end_time, req_delay_time);

   // live point at the scan index that is due and beats the best so far
   assign cand = pt_live_ff[pidx_ff] && (cur_trig <= time_ff) &&
                 (!found_ff || cur_trig < btrig_ff ||
                  (cur_trig == btrig_ff && pt_ident_ff[pidx_ff] < bid_ff));

   always_comb begin
      state_in    = state_ff;
      time_in     = time_ff;
      next_id_in  = next_id_ff;
      pt_live_in  = pt_live_ff;
      rg_live_in  = rg_live_ff;
      rg_begun_in = rg_begun_ff;
      pidx_in     = pidx_ff;
      found_in    = found_ff;
      btrig_in    = btrig_ff;
      bid_in      = bid_ff;
      bowner_in   = bowner_ff;
      bslot_in    = bslot_ff;
      ridx_in     = ridx_ff;
      pt_we       = 1'b0;
      pt_wslot    = pfree_slot;
      pt_wtrig    = add_trig;
      rg_we       = 1'b0;
      rg_wslot    = rfree_slot;
      rg_wstart   = add_start;
      rg_wend     = add_end;
      div_start   = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = KIND_DONE;
      rsp_id_in    = 16'd0;
      rsp_owner_in = 8'd0;
      rsp_prog_in  = 17'd0;
      rsp_last_in  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_func)
                  FUNC_TICK: begin
                     time_in  = sat_add(time_ff, req_tick_delta);
                     pidx_in  = '0;
                     found_in = 1'b0;
                     state_in = ST_PSCAN;
                  end
                  FUNC_ADD_PT_ABS, FUNC_ADD_PT_DLY: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     rsp_owner_in = req_owner_tag;
                     if (pfree_found) begin
                        pt_we                  = 1'b1;
                        pt_live_in[pfree_slot] = 1'b1;
                        rsp_kind_in            = KIND_ASSIGNED;
                        rsp_id_in              = next_id_ff;
                        next_id_in             = next_id_ff + 16'd1;
                     end else begin
                        rsp_kind_in = KIND_FULL;
                     end
                  end
                  FUNC_ADD_RG_ABS, FUNC_ADD_RG_DLY: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     rsp_owner_in = req_owner_tag;
                     if (rfree_found) begin
                        rg_we                   = 1'b1;
                        rg_live_in[rfree_slot]  = 1'b1;
                        rg_begun_in[rfree_slot] = 1'b0;
                        rsp_kind_in             = KIND_ASSIGNED;
                        rsp_id_in               = next_id_ff;
                        next_id_in              = next_id_ff + 16'd1;
                     end else begin
                        rsp_kind_in = KIND_FULL;
                     end
                  end
                  FUNC_STOP: begin
                     // a point with the id wins over a range with the same id
                     if (pstop_found) begin
                        pt_live_in[pstop_slot] = 1'b0;
                     end else if (rstop_found) begin
                        rg_live_in[rstop_slot]  = 1'b0;
                        rg_begun_in[rstop_slot] = 1'b0;
                     end
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     rsp_id_in    = req_target_id;
                  end
                  FUNC_REMOVE: begin
                     for (int i = 0; i < POINT_SLOTS; i++) begin
                        if (pt_owner_ff[i] == req_owner_tag) begin
                           pt_live_in[i] = 1'b0;
                        end
                     end
                     for (int j = 0; j < RANGE_SLOTS; j++) begin
                        if (rg_live_ff[j] && rg_owner_ff[j] == req_owner_tag) begin
                           rg_live_in[j]  = 1'b0;
                           rg_begun_in[j] = 1'b0;
                        end
                     end
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     rsp_owner_in = req_owner_tag;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                  end
               endcase
            end
         end
         ST_PSCAN: begin
            // one slot per cycle through the shared comparator
            if (cand) begin
               found_in  = 1'b1;
               btrig_in  = cur_trig;
               bid_in    = pt_ident_ff[pidx_ff];
               bowner_in = pt_owner_ff[pidx_ff];
               bslot_in  = pidx_ff;
            end
            if (pidx_ff == PLAST) begin
               if (found_ff || cand) begin
                  state_in = ST_PFIRE;
               end else begin
                  ridx_in  = '0;
                  state_in = ST_RCHK;
               end
            end else begin
               pidx_in = pidx_ff + PW'(1);
            end
         end
         ST_PFIRE: begin
            pt_live_in[bslot_ff] = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_FIRED;
            rsp_id_in    = bid_ff;
            rsp_owner_in = bowner_ff;
            pidx_in      = '0;
            found_in     = 1'b0;
            state_in     = ST_PSCAN;
         end
         ST_RCHK: begin
            if (!rg_live_ff[ridx_ff]) begin
               if (ridx_ff == RLAST) begin
                  state_in = ST_DONE;
               end else begin
                  ridx_in = ridx_ff + RW'(1);
               end
            end else if (!rg_begun_ff[ridx_ff] && time_ff >= cur_start) begin
               rg_begun_in[ridx_ff] = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_STARTED;
               rsp_id_in    = rg_ident_ff[ridx_ff];
               rsp_owner_in = rg_owner_ff[ridx_ff];
               state_in     = ST_RPROG;
            end else if (rg_begun_ff[ridx_ff]) begin
               state_in = ST_RPROG;
            end else begin
               state_in = ST_REND;
            end
         end
         ST_RPROG: begin
            rsp_id_in    = rg_ident_ff[ridx_ff];
            rsp_owner_in = rg_owner_ff[ridx_ff];
            rsp_kind_in  = KIND_PROGRESS;
            // empty range or past the end is complete, at or before the start is zero
            if (cur_end <= cur_start || time_ff >= cur_end) begin
               rsp_valid_in = 1'b1;
               rsp_prog_in  = FULL_PROGRESS;
               state_in     = ST_REND;
            end else if (time_ff <= cur_start) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_REND;
            end else begin
               div_start = 1'b1;
               state_in  = ST_RDIV;
            end
         end
         ST_RDIV: begin
            if (div_stat.done) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_PROGRESS;
               rsp_id_in    = rg_ident_ff[ridx_ff];
               rsp_owner_in = rg_owner_ff[ridx_ff];
               rsp_prog_in  = {1'b0, div_stat.quotient};
               state_in     = ST_REND;
            end
         end
         ST_REND: begin
            if (time_ff >= cur_end) begin
               rg_live_in[ridx_ff]  = 1'b0;
               rg_begun_in[ridx_ff] = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ENDED;
               rsp_id_in    = rg_ident_ff[ridx_ff];
               rsp_owner_in = rg_owner_ff[ridx_ff];
            end
            if (ridx_ff == RLAST) begin
               state_in = ST_DONE;
            end else begin
               ridx_in  = ridx_ff + RW'(1);
               state_in = ST_RCHK;
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         time_ff      <= 32'd0;
         next_id_ff   <= 16'd0;
         pt_live_ff   <= '0;
         rg_live_ff   <= '0;
         rg_begun_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_ff      <= time_in;
         next_id_ff   <= next_id_in;
         pt_live_ff   <= pt_live_in;
         rg_live_ff   <= rg_live_in;
         rg_begun_ff  <= rg_begun_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pidx_ff      <= pidx_in;
      found_ff     <= found_in;
      btrig_ff     <= btrig_in;
      bid_ff       <= bid_in;
      bowner_ff    <= bowner_in;
      bslot_ff     <= bslot_in;
      ridx_ff      <= ridx_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_owner_ff <= rsp_owner_in;
      rsp_prog_ff  <= rsp_prog_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // table payload, written at one slot on an add
   always_ff @(posedge clock) begin
      if (pt_we) begin
         pt_trig_ff[pt_wslot]  <= pt_wtrig;
         pt_ident_ff[pt_wslot] <= next_id_ff;
         pt_owner_ff[pt_wslot] <= req_owner_tag;
      end
      if (rg_we) begin
         rg_start_ff[rg_wslot] <= rg_wstart;
         rg_end_ff[rg_wslot]   <= rg_wend;
         rg_ident_ff[rg_wslot] <= next_id_ff;
         rg_owner_ff[rg_wslot] <= req_owner_tag;
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_event_id    = rsp_id_ff;
   assign rsp_event_owner = rsp_owner_ff;
   assign rsp_progress    = rsp_prog_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

@@ src/tes_checker.sv @@
// port-level checks for the timeline event scheduler, bound to the top level
// depends on tes_pkg and timeline_event_scheduler_assert.svh
`include "timeline_event_scheduler_assert.svh"

module tes_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [2:0]  req_func,
   input logic [31:0] req_tick_delta,
   input logic [31:0] req_start_time,
   input logic [31:0] req_end_time,
   input logic [31:0] req_delay_time,
   input logic [7:0]  req_owner_tag,
   input logic [15:0] req_target_id,
   input logic        rsp_valid,
   input logic [2:0]  rsp_kind,
   input logic [15:0] rsp_event_id,
   input logic [7:0]  rsp_event_owner,
   input logic [16:0] rsp_progress,
   input logic        rsp_last
);
   import tes_pkg::*;

   // an accepted command either answers at once or keeps the block busy
   `TES_ASSERT_NXT(a_accept_answers, clock, reset, start && !busy, rsp_valid || busy)
   // only progress results carry a progress value
   `TES_ASSERT_IMP(a_prog_only, clock, reset, rsp_valid && rsp_kind != KIND_PROGRESS, rsp_progress == 17'd0)
   // a done result always closes its command
   `TES_ASSERT_IMP(a_done_last, clock, reset, rsp_valid && rsp_kind == KIND_DONE, rsp_last)
   // tick callbacks never close a command
   `TES_ASSERT_IMP(a_last_kind, clock, reset, rsp_valid && rsp_last, rsp_kind == KIND_DONE || rsp_kind == KIND_ASSIGNED || rsp_kind == KIND_FULL)

endmodule

bind timeline_event_scheduler tes_checker u_tes_checker (.*);

@@ sim/tb.sv @@
// self-checking testbench for timeline_event_scheduler: directed and random commands
// results are predicted by an independent behavioral model kept inside this file
// depends on tes_pkg and the scheduler rtl
`timescale 1ns / 1ps

module tb;
   import tes_pkg::*;

   localparam int NUM_POINTS = 16;
   localparam int NUM_RANGES = 8;
   localparam int STALL_LIMIT = 4000;
   localparam logic [2:0] FUNC_UNUSED = 3'd7;

   typedef struct {
      logic [2:0]  kind;
      logic [15:0] id;
      logic [7:0]  owner;
      logic [16:0] prog;
      logic        last;
   } sched_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_func = '0;
   logic [31:0] req_tick_delta = '0;
   logic [31:0] req_start_time = '0;
   logic [31:0] req_end_time = '0;
   logic [31:0] req_delay_time = '0;
   logic [7:0]  req_owner_tag = '0;
   logic [15:0] req_target_id = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_kind;
   logic [15:0] rsp_event_id;
   logic [7:0]  rsp_event_owner;
   logic [16:0] rsp_progress;
   logic        rsp_last;

   // expected results in arrival order
   sched_rsp_type expected_rsp[$];
   int         mismatch_count = 0;
   int         idle_pct = 0;
   int         stall_cycles = 0;

   // behavioral copy of the scheduler state
   logic [31:0] now_q;
   logic [15:0] next_id;
   logic        pt_live [NUM_POINTS];
   logic [31:0] pt_trig [NUM_POINTS];
   logic [15:0] pt_id   [NUM_POINTS];
   logic [7:0]  pt_own  [NUM_POINTS];
   logic        rg_live [NUM_RANGES];
   logic        rg_begun[NUM_RANGES];
   logic [31:0] rg_beg  [NUM_RANGES];
   logic [31:0] rg_fin  [NUM_RANGES];
   logic [15:0] rg_id   [NUM_RANGES];
   logic [7:0]  rg_own  [NUM_RANGES];

   always #5 clock = ~clock;

   timeline_event_scheduler i_dut (.*);

   function automatic logic [31:0] clamp_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic void push_rsp(logic [2:0] k, logic [15:0] id, logic [7:0] own,
                                    logic [16:0] prog);
      sched_rsp_type r;
      r.kind = k; r.id = id; r.owner = own; r.prog = prog; r.last = 1'b0;
      expected_rsp.insert(expected_rsp.size(), r);
   endfunction

   // progress in Q1.16, clamped, empty range counts as complete
   function automatic logic [16:0] range_fraction(int s);
      logic [63:0] num;
      logic [63:0] den;
      if (rg_fin[s] <= rg_beg[s] || now_q >= rg_fin[s]) return FULL_PROGRESS;
      if (now_q <= rg_beg[s]) return '0;
      num = {32'd0, now_q - rg_beg[s]} << 16;
      den = {32'd0, rg_fin[s] - rg_beg[s]};
      return 17'(num / den);
   endfunction

   function automatic void sched_reset();
      now_q = '0;
      next_id = '0;
      foreach (pt_live[i]) pt_live[i] = 1'b0;
      foreach (rg_live[i]) begin
         rg_live[i] = 1'b0;
         rg_begun[i] = 1'b0;
      end
   endfunction

   function automatic void predict_tick(logic [31:0] delta);
      int best;
      now_q = clamp_add(now_q, delta);
      // fire due points, earliest trigger first, then lowest id, then lowest slot
      forever begin
         best = -1;
         for (int s = 0; s < NUM_POINTS; s++) begin
            if (!pt_live[s] || pt_trig[s] > now_q) continue;
            if (best < 0 || pt_trig[s] < pt_trig[best] ||
                (pt_trig[s] == pt_trig[best] && pt_id[s] < pt_id[best]))
               best = s;
         end
         if (best < 0) break;
         pt_live[best] = 1'b0;
         push_rsp(KIND_FIRED, pt_id[best], pt_own[best], '0);
      end
      for (int s = 0; s < NUM_RANGES; s++) begin
         if (!rg_live[s]) continue;
         if (!rg_begun[s] && now_q >= rg_beg[s]) begin
            rg_begun[s] = 1'b1;
            push_rsp(KIND_STARTED, rg_id[s], rg_own[s], '0);
         end
         if (rg_begun[s]) push_rsp(KIND_PROGRESS, rg_id[s], rg_own[s], range_fraction(s));
         if (now_q >= rg_fin[s]) begin
            rg_live[s] = 1'b0;
            rg_begun[s] = 1'b0;
            push_rsp(KIND_ENDED, rg_id[s], rg_own[s], '0);
         end
      end
      push_rsp(KIND_DONE, '0, '0, '0);
   endfunction

   function automatic void predict_point(logic [31:0] trig, logic [7:0] own);
      for (int s = 0; s < NUM_POINTS; s++) begin
         if (!pt_live[s]) begin
            pt_live[s] = 1'b1;
            pt_trig[s] = trig;
            pt_id[s] = next_id;
            pt_own[s] = own;
            push_rsp(KIND_ASSIGNED, next_id, own, '0);
            next_id = next_id + 16'd1;
            return;
         end
      end
      push_rsp(KIND_FULL, '0, own, '0);
   endfunction

   function automatic void predict_range(logic [31:0] b, logic [31:0] e, logic [7:0] own);
      for (int s = 0; s < NUM_RANGES; s++) begin
         if (!rg_live[s]) begin
            rg_live[s] = 1'b1;
            rg_begun[s] = 1'b0;
            rg_beg[s] = b;
            rg_fin[s] = e;
            rg_id[s] = next_id;
            rg_own[s] = own;
            push_rsp(KIND_ASSIGNED, next_id, own, '0);
            next_id = next_id + 16'd1;
            return;
         end
      end
      push_rsp(KIND_FULL, '0, own, '0);
   endfunction

   function automatic void predict_stop(logic [15:0] id);
      push_rsp(KIND_DONE, id, '0, '0);
      for (int s = 0; s < NUM_POINTS; s++)
         if (pt_live[s] && pt_id[s] == id) begin
            pt_live[s] = 1'b0;
            return;
         end
      for (int s = 0; s < NUM_RANGES; s++)
         if (rg_live[s] && rg_id[s] == id) begin
            rg_live[s] = 1'b0;
            rg_begun[s] = 1'b0;
            return;
         end
   endfunction

   function automatic void predict_remove(logic [7:0] own);
      for (int s = 0; s < NUM_POINTS; s++)
         if (pt_live[s] && pt_own[s] == own) pt_live[s] = 1'b0;
      for (int s = 0; s < NUM_RANGES; s++)
         if (rg_live[s] && rg_own[s] == own) begin
            rg_live[s] = 1'b0;
            rg_begun[s] = 1'b0;
         end
      push_rsp(KIND_DONE, '0, own, '0);
   endfunction

   function automatic void predict_cmd(logic [2:0] f, logic [31:0] delta, logic [31:0] st,
                                       logic [31:0] en, logic [31:0] dl, logic [7:0] own,
                                       logic [15:0] tgt);
      case (f)
         FUNC_TICK:       predict_tick(delta);
         FUNC_ADD_PT_ABS: predict_point(st, own);
         FUNC_ADD_PT_DLY: predict_point(clamp_add(now_q, dl), own);
         FUNC_ADD_RG_ABS: predict_range(st, en, own);
         FUNC_ADD_RG_DLY: predict_range(clamp_add(st, dl), clamp_add(en, dl), own);
         FUNC_STOP:       predict_stop(tgt);
         FUNC_REMOVE:     predict_remove(own);
         default:         push_rsp(KIND_DONE, '0, '0, '0);
      endcase
      // only the final result of a command carries last
      expected_rsp[expected_rsp.size() - 1].last = 1'b1;
   endfunction

   // one command transfer; start stays high if the next command follows at once
   task automatic send_cmd(logic [2:0] f, logic [31:0] delta, logic [31:0] st,
                           logic [31:0] en, logic [31:0] dl, logic [7:0] own,
                           logic [15:0] tgt);
      int gap;
      gap = (idle_pct > 0 && $urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_func <= f;
      req_tick_delta <= delta;
      req_start_time <= st;
      req_end_time <= en;
      req_delay_time <= dl;
      req_owner_tag <= own;
      req_target_id <= tgt;
      do @(posedge clock); while (busy);
      predict_cmd(f, delta, st, en, dl, own, tgt);
   endtask

   // wait until every expected result has come back
   task automatic drain();
      start <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   // result checker: every strobed result is compared with the oldest expectation
   always @(posedge clock) begin
      sched_rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected result kind %0d id %0d", rsp_kind, rsp_event_id);
            mismatch_count++;
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_kind !== e.kind) begin
               $error("kind: expected %0d actual %0d", e.kind, rsp_kind);
               mismatch_count++;
            end
            if (rsp_event_id !== e.id) begin
               $error("event_id: expected %0d actual %0d", e.id, rsp_event_id);
               mismatch_count++;
            end
            if (rsp_event_owner !== e.owner) begin
               $error("event_owner: expected %0d actual %0d", e.owner, rsp_event_owner);
               mismatch_count++;
            end
            if (rsp_progress !== e.prog) begin
               $error("progress: expected %0d actual %0d", e.prog, rsp_progress);
               mismatch_count++;
            end
            if (rsp_last !== e.last) begin
               $error("last: expected %0d actual %0d", e.last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog: cycles with neither a command transfer nor a result
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // point and range adds, ticks, stop hit and miss, owner removal, unused selector
   task automatic test_directed_basics();
      send_cmd(FUNC_ADD_PT_ABS, '0, 32'h0002_0000, '0, '0, 8'hFF, '0);
      send_cmd(FUNC_ADD_PT_ABS, '0, 32'h0002_0000, '0, '0, 8'h01, '0);  // tie on trigger
      send_cmd(FUNC_ADD_PT_DLY, '0, '0, '0, 32'h0001_0000, 8'h02, '0);
      send_cmd(FUNC_ADD_RG_ABS, '0, 32'h0001_0000, 32'h0003_0000, '0, 8'h03, '0);
      send_cmd(FUNC_ADD_RG_ABS, '0, 32'h0005_0000, 32'h0004_0000, '0, 8'h04, '0); // empty
      send_cmd(FUNC_ADD_RG_DLY, '0, 32'h0000_8000, 32'h0002_0000, 32'h0000_4000, 8'h05,
               '0);
      send_cmd(FUNC_TICK, '0, '0, '0, '0, '0, '0);
      send_cmd(FUNC_TICK, 32'h0001_0000, '0, '0, '0, '0, '0);
      send_cmd(FUNC_STOP, '0, '0, '0, '0, '0, 16'd5);
      send_cmd(FUNC_STOP, '0, '0, '0, '0, '0, 16'hFFFF);                // no such id
      send_cmd(FUNC_TICK, 32'h0001_8000, '0, '0, '0, '0, '0);
      send_cmd(FUNC_REMOVE, '0, '0, '0, '0, 8'h04, '0);
      send_cmd(FUNC_UNUSED, '1, '1, '1, '1, '1, '1);
      // delayed adds that saturate, then a tick that saturates the clock
      send_cmd(FUNC_ADD_PT_DLY, '0, '0, '0, 32'hFFFF_FFFF, 8'h06, '0);
      send_cmd(FUNC_ADD_RG_DLY, '0, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0010_0000, 8'h07,
               '0);
      send_cmd(FUNC_TICK, 32'hFFFF_FFFF, '0, '0, '0, '0, '0);
      drain();
   endtask

   // fill the range table, one add past full, then clear by owner
   task automatic test_table_full();
      for (int i = 0; i <= NUM_RANGES; i++)
         send_cmd(FUNC_ADD_RG_ABS, '0, '1, '1, '0, 8'hA5, '0);
      send_cmd(FUNC_REMOVE, '0, '0, '0, '0, 8'hA5, '0);
      drain();
   endtask

   // random mix around the running clock so events actually start, fire and end
   task automatic test_random_mix(int n_items, int pct);
      logic [2:0]  f;
      logic [31:0] delta, st, en, dl;
      logic [7:0]  own;
      logic [15:0] tgt;
      int          pick;
      idle_pct = pct;
      for (int i = 0; i < n_items; i++) begin
         delta = $urandom(); st = $urandom(); en = $urandom(); dl = $urandom();
         own = $urandom(); tgt = $urandom();
         pick = $urandom_range(99);
         if (pick < 30) begin
            f = FUNC_TICK;
            if ($urandom_range(49) != 0) delta = $urandom_range(0, 32'h0002_0000);
         end else if (pick < 45) begin
            f = FUNC_ADD_PT_ABS;
            if ($urandom_range(9) != 0) st = clamp_add(now_q, $urandom_range(0, 32'h0004_0000));
         end else if (pick < 55) begin
            f = FUNC_ADD_PT_DLY;
            if ($urandom_range(9) != 0) dl = $urandom_range(0, 32'h0004_0000);
         end else if (pick < 70) begin
            f = FUNC_ADD_RG_ABS;
            if ($urandom_range(9) != 0) begin
               st = clamp_add(now_q, $urandom_range(0, 32'h0002_0000));
               en = clamp_add(st, $urandom_range(0, 32'h0004_0000));
               if ($urandom_range(7) == 0) en = st - $urandom_range(0, 32'h100);
            end
         end else if (pick < 80) begin
            f = FUNC_ADD_RG_DLY;
            if ($urandom_range(9) != 0) begin
               st = now_q;
               en = clamp_add(st, $urandom_range(0, 32'h0004_0000));
               dl = $urandom_range(0, 32'h0002_0000);
            end
         end else if (pick < 88) begin
            f = FUNC_STOP;
            if ($urandom_range(3) != 0) tgt = next_id - 16'($urandom_range(1, 8));
         end else if (pick < 96) begin
            f = FUNC_REMOVE;
         end else begin
            f = FUNC_UNUSED;
         end
         // a handful of owners so removal has something to hit
         if (f != FUNC_TICK && $urandom_range(9) < 7) own = 8'($urandom_range(0, 3));
         send_cmd(f, delta, st, en, dl, own, tgt);
      end
      drain();
   endtask

   initial begin
      sched_reset();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_basics();
      test_table_full();
      // random phases: no idle gaps, a gap before about half the commands, then a quarter
      test_random_mix(30, 0);
      test_random_mix(25, 50);
      test_random_mix(25, 25);
      start <= 1'b0;
      repeat (600) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
